// ===== rtl/plc_pkg.sv =====
// pinned lru object cache: shared types and codes
// no dependencies
`timescale 1ns / 1ps
package plc_pkg;
    localparam int KEY_BITS   = 32;
    localparam int COUNT_BITS = 8;

    localparam logic [2:0] MODE_PUT    = 3'd0;
    localparam logic [2:0] MODE_GET    = 3'd1;
    localparam logic [2:0] MODE_REL    = 3'd2;
    localparam logic [2:0] MODE_REMOVE = 3'd3;
    localparam logic [2:0] MODE_FLUSH  = 3'd4;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_MISS = 3'd1;
    localparam logic [2:0] ST_NUSE = 3'd2;
    localparam logic [2:0] ST_DUP  = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    localparam logic KIND_ANS = 1'b0;
    localparam logic KIND_WB  = 1'b1;

    // per-cell command broadcast by the controller
    typedef struct packed {
        logic unlink;     // meant to drop target from recency list; no cell reads it
        logic push;       // age all cached entries by one
        logic age_dec;    // decrement cached ages above ref_age
        logic flush_drop; // invalidate every cached entry
    } plc_cmd_t;
endpackage

// ===== rtl/plc_cell.sv =====
// pinned lru object cache: one table slot with key, count, age and match
// depends on plc_pkg
`timescale 1ns / 1ps
module plc_cell #(
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 8,
    parameter int AGE_BITS   = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [KEY_BITS-1:0]   look_key,
    input  logic                  sel,
    input  logic                  wr_valid,
    input  logic                  wr_key_en,
    input  logic [KEY_BITS-1:0]   wr_key,
    input  logic                  wr_cached,
    input  logic [COUNT_BITS-1:0] wr_count,
    input  logic                  wr_en,
    input  plc_pkg::plc_cmd_t     cmd,
    input  logic [AGE_BITS-1:0]   ref_age,
    output logic                  hit,
    output logic                  valid,
    output logic                  cached,
    output logic [KEY_BITS-1:0]   key,
    output logic [COUNT_BITS-1:0] count,
    output logic [AGE_BITS-1:0]   age
);
    import plc_pkg::*;

    logic                  valid_reg, cached_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [AGE_BITS-1:0]   age_reg;
    logic                  is_c;

    assign is_c = valid_reg && cached_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            cached_reg <= 1'b0;
            count_reg  <= '0;
            age_reg    <= '0;
        end
        else
        begin
            if (cmd.flush_drop && is_c)
            begin
                valid_reg  <= 1'b0;
                cached_reg <= 1'b0;
                age_reg    <= '0;
                count_reg  <= '0;
            end
            else if (sel && wr_en)
            begin
                valid_reg  <= wr_valid;
                cached_reg <= wr_cached;
                count_reg  <= wr_count;
                age_reg    <= '0;
            end
            else if (is_c)
            begin
                if (cmd.push)
                    age_reg <= age_reg + 1'b1;
                else if (cmd.age_dec && age_reg > ref_age)
                    age_reg <= age_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && wr_en && wr_key_en)
            key_reg <= wr_key;
    end

    assign hit    = valid_reg && (key_reg == look_key);
    assign valid  = valid_reg;
    assign cached = cached_reg;
    assign key    = key_reg;
    assign count  = count_reg;
    assign age    = age_reg;
endmodule

// ===== rtl/pinned_lru_object_cache_top.sv =====
// pinned lru object cache: top level, controller and row of slot cells
// depends on plc_pkg, plc_cell
//  channel | dir | beat contents
//  s_axis  | in  | tdata: mode[2:0] key[34:3] pin[35]
//  m_axis  | out | tdata: out_key[31:0] status[34:32] count[42:35]; tuser kind; tlast
//  cfg     | in  | max_cached[5:0]
// a new command is taken only in idle, after the answer beat of the last one is accepted
// a put with no free slot first evicts the oldest cached entry; an unpinned put or a release to zero then trims
// evictions write the key back; flush writes back every pinned, then every cached entry, then answers
// a beat waiting on the receiver holds the controller; reset clears the whole table
`timescale 1ns / 1ps
module pinned_lru_object_cache_top #(
    parameter int SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // mode, key, pin
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // out_key, status, count
    output logic        m_axis_tuser,  // kind
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data       // max_cached
);
    import plc_pkg::*;

    localparam int IB = $clog2(SLOTS);
    localparam int AB = $clog2(SLOTS);
    localparam int TB = $clog2(SLOTS + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    localparam logic [3:0] S_IDLE = 4'd0, S_LOOK = 4'd1, S_DO = 4'd2,
                           S_EVS = 4'd3, S_EVD = 4'd4, S_INS = 4'd5,
                           S_TRIM = 4'd6, S_ANS = 4'd7, S_FP = 4'd8,
                           S_FC = 4'd9, S_FDROP = 4'd10, S_OUT = 4'd11;

    logic [3:0]            state_reg, state_next, ret_reg;
    logic [2:0]            mode_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic                  pin_reg;
    logic [5:0]            maxc_reg;
    logic [TB-1:0]         total_reg;
    logic [IB-1:0]         tgt_reg, scan_reg;
    logic [TB-1:0]         fage_reg;
    logic                  found_reg;
    logic [2:0]            stat_reg;
    logic                  dup_c_reg;
    logic [47:0]           od_reg;
    logic                  okind_reg, olast_reg, ovalid_reg;

    logic [SLOTS-1:0]      hit, vld, cch;
    logic [KEY_BITS-1:0]   ck [SLOTS];
    logic [COUNT_BITS-1:0] cc [SLOTS];
    logic [AB-1:0]         ca [SLOTS];

    logic                  wr_en, wr_valid, wr_cached, wr_key_en;
    logic [COUNT_BITS-1:0] wr_count;
    plc_cmd_t              cmd;
    logic [AB-1:0]         ref_age;

    logic                  any_hit, any_free, any_c;
    logic [IB-1:0]         hit_i, free_i, old_i;
    logic [TB-1:0]         lim;

    // oldest cached entry is the one whose age is total - 1
    always_comb
    begin
        any_hit = 1'b0; hit_i = '0; any_free = 1'b0; free_i = '0;
        any_c = 1'b0; old_i = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (hit[i]) begin any_hit = 1'b1; hit_i = IB'(i); end
            if (!vld[i]) begin any_free = 1'b1; free_i = IB'(i); end
        end
        for (int i = 0; i < SLOTS; i++)
            if (vld[i] && cch[i] && TB'(ca[i]) == total_reg - TB'(1))
            begin
                any_c = 1'b1; old_i = IB'(i);
            end
    end

    assign lim = (maxc_reg == 6'd0) ? TB'(1) : TB'(maxc_reg);

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            plc_cell #(.KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS), .AGE_BITS(AB)) u_cell (
                .clk(clk), .rst_n(rst_n), .look_key(key_reg),
                .sel(tgt_reg == IB'(g)), .wr_valid(wr_valid), .wr_key_en(wr_key_en),
                .wr_key(key_reg), .wr_cached(wr_cached), .wr_count(wr_count),
                .wr_en(wr_en), .cmd(cmd), .ref_age(ref_age),
                .hit(hit[g]), .valid(vld[g]), .cached(cch[g]), .key(ck[g]),
                .count(cc[g]), .age(ca[g])
            );
        end
    endgenerate

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;

    // control signals for the cells, one command per cycle
    always_comb
    begin
        state_next = state_reg;
        wr_en = 1'b0; wr_valid = 1'b0; wr_cached = 1'b0; wr_key_en = 1'b0;
        wr_count = '0; cmd = '0; ref_age = ca[tgt_reg];
        unique case (state_reg)
            S_DO:
            begin
                priority case (mode_reg)
                    MODE_PUT:
                        if (found_reg && cch[tgt_reg])
                        begin
                            cmd.age_dec = 1'b1; wr_en = 1'b1;
                            wr_valid = 1'b1;
                        end
                    MODE_GET:
                        if (found_reg)
                        begin
                            wr_en = 1'b1; wr_valid = 1'b1;
                            if (cch[tgt_reg])
                            begin
                                cmd.age_dec = 1'b1; wr_count = COUNT_BITS'(1);
                            end
                            else
                                wr_count = (cc[tgt_reg] == CMAX) ? CMAX
                                         : cc[tgt_reg] + 1'b1;
                        end
                    MODE_REL:
                        if (found_reg && !cch[tgt_reg] && cc[tgt_reg] > COUNT_BITS'(1))
                        begin
                            wr_en = 1'b1; wr_valid = 1'b1;
                            wr_count = cc[tgt_reg] - 1'b1;
                        end
                    MODE_REMOVE:
                        if (found_reg)
                        begin
                            wr_en = 1'b1;
                            cmd.age_dec = cch[tgt_reg];
                        end
                    default: ;
                endcase
            end
            S_EVD:
            begin
                wr_en = 1'b1; cmd.age_dec = 1'b1;
            end
            S_INS:
            begin
                wr_en = 1'b1; wr_valid = 1'b1; wr_key_en = (mode_reg == MODE_PUT);
                if (mode_reg == MODE_PUT && pin_reg)
                    wr_count = COUNT_BITS'(1);
                else
                begin
                    wr_cached = 1'b1; cmd.push = 1'b1;
                end
            end
            S_FDROP: cmd.flush_drop = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            maxc_reg   <= 6'd16;
            total_reg  <= '0;
            ovalid_reg <= 1'b0;
            tgt_reg    <= '0;
            scan_reg   <= '0;
            fage_reg   <= '0;
            found_reg  <= 1'b0;
            stat_reg   <= ST_OK;
            dup_c_reg  <= 1'b0;
            mode_reg   <= MODE_PUT;
            key_reg    <= '0;
            pin_reg    <= 1'b0;
            od_reg     <= '0;
            okind_reg  <= KIND_ANS;
            olast_reg  <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
                state_reg  <= ret_reg;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                        maxc_reg <= cfg_data;
                    if (s_axis_tvalid)
                    begin
                        mode_reg  <= s_axis_tdata[2:0];
                        key_reg   <= s_axis_tdata[KEY_BITS+2:3];
                        pin_reg   <= s_axis_tdata[35];
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    found_reg <= any_hit;
                    tgt_reg   <= any_hit ? hit_i : free_i;
                    dup_c_reg <= 1'b0;
                    stat_reg  <= ST_OK;
                    scan_reg  <= '0;
                    fage_reg  <= '0;
                    state_reg <= (mode_reg == MODE_FLUSH) ? S_FP : S_DO;
                end
                S_DO:
                begin
                    state_reg <= S_ANS;
                    priority case (mode_reg)
                        MODE_PUT:
                        begin
                            if (found_reg)
                            begin
                                stat_reg <= ST_DUP;
                                if (cch[tgt_reg]) total_reg <= total_reg - 1'b1;
                                state_reg <= S_INS;
                            end
                            else if (any_free)
                                state_reg <= S_INS;
                            else if (any_c)
                            begin
                                tgt_reg <= old_i; state_reg <= S_EVS;
                            end
                            else
                                stat_reg <= ST_FULL;
                        end
                        MODE_GET:
                        begin
                            if (!found_reg) stat_reg <= ST_MISS;
                            else if (cch[tgt_reg]) total_reg <= total_reg - 1'b1;
                        end
                        MODE_REL:
                        begin
                            if (!found_reg || cch[tgt_reg]) stat_reg <= ST_NUSE;
                            else if (cc[tgt_reg] <= COUNT_BITS'(1)) state_reg <= S_INS;
                        end
                        MODE_REMOVE:
                        begin
                            if (!found_reg) stat_reg <= ST_MISS;
                            else
                            begin
                                if (cch[tgt_reg]) total_reg <= total_reg - 1'b1;
                                od_reg <= {16'd0, 32'(ck[tgt_reg])};
                                okind_reg <= KIND_WB; olast_reg <= 1'b0;
                                ovalid_reg <= 1'b1; ret_reg <= S_ANS;
                                state_reg <= S_OUT;
                            end
                        end
                        default: stat_reg <= ST_MISS;
                    endcase
                end
                S_EVS:
                begin
                    od_reg <= {16'd0, 32'(ck[tgt_reg])};
                    okind_reg <= KIND_WB; olast_reg <= 1'b0;
                    ovalid_reg <= 1'b1; ret_reg <= S_EVD;
                    state_reg <= S_OUT;
                end
                S_EVD:
                begin
                    total_reg <= total_reg - 1'b1;
                    state_reg <= (mode_reg == MODE_PUT && !found_reg && !dup_c_reg)
                                 ? S_INS : S_TRIM;
                    dup_c_reg <= 1'b1;
                end
                S_INS:
                begin
                    if (!(mode_reg == MODE_PUT && pin_reg))
                    begin
                        total_reg <= total_reg + 1'b1;
                        state_reg <= S_TRIM;
                    end
                    else
                        state_reg <= S_ANS;
                    dup_c_reg <= 1'b1;
                end
                S_TRIM:
                begin
                    if (total_reg > lim && any_c)
                    begin
                        tgt_reg <= old_i; state_reg <= S_EVS;
                    end
                    else
                    begin
                        tgt_reg <= any_hit ? hit_i : tgt_reg;
                        state_reg <= S_ANS;
                    end
                end
                S_ANS:
                begin
                    od_reg <= {5'd0,
                        (stat_reg == ST_OK || stat_reg == ST_DUP)
                          && found_reg | (mode_reg == MODE_PUT) && vld[tgt_reg]
                          && mode_reg != MODE_REMOVE && mode_reg != MODE_FLUSH
                          && hit[tgt_reg] ? 8'(cc[tgt_reg]) : 8'd0,
                        stat_reg,
                        mode_reg == MODE_FLUSH ? 32'd0 : 32'(key_reg)};
                    okind_reg <= KIND_ANS; olast_reg <= 1'b1;
                    ovalid_reg <= 1'b1; ret_reg <= S_IDLE;
                    state_reg <= S_OUT;
                end
                S_FP:
                begin
                    if (vld[scan_reg] && !cch[scan_reg])
                    begin
                        od_reg <= {16'd0, 32'(ck[scan_reg])};
                        okind_reg <= KIND_WB; olast_reg <= 1'b0;
                        ovalid_reg <= 1'b1; state_reg <= S_OUT;
                        ret_reg <= (scan_reg == IB'(SLOTS - 1)) ? S_FC : S_FP;
                    end
                    else if (scan_reg == IB'(SLOTS - 1))
                        state_reg <= S_FC;
                    scan_reg <= scan_reg + 1'b1;
                end
                S_FC:
                begin
                    if (fage_reg >= total_reg)
                        state_reg <= S_FDROP;
                    else
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            if (vld[i] && cch[i] && TB'(ca[i]) == fage_reg)
                                od_reg <= {16'd0, 32'(ck[i])};
                        okind_reg <= KIND_WB; olast_reg <= 1'b0;
                        ovalid_reg <= 1'b1; ret_reg <= S_FC;
                        state_reg <= S_OUT;
                        fage_reg <= fage_reg + 1'b1;
                    end
                end
                S_FDROP:
                begin
                    total_reg <= '0;
                    state_reg <= S_ANS;
                end
                S_OUT: ;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TB'(SLOTS))
        else $error("cached total overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit))
        else $error("duplicate key in table");
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken with result pending");
endmodule

// ===== dv/tb_pinned_lru_object_cache_top.sv =====
// testbench for pinned_lru_object_cache_top: directed table and full-table case, then random traffic
// checks each output beat against a behavioral model of the cache; depends on plc_pkg, pinned_lru_object_cache_top
`timescale 1ns / 1ps
module tb_pinned_lru_object_cache_top;
    import plc_pkg::*;

    localparam int SLOTS = 32;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic        kind;
        logic [31:0] okey;
        logic [2:0]  status;
        logic [7:0]  cnt;
        logic        last;
    } beat_t;

    typedef struct {
        logic [2:0]  mode;
        logic [31:0] key;
        logic        pin;
        logic        chk;
        logic [2:0]  exp_status;
        logic [7:0]  exp_count;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;

    pinned_lru_object_cache_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // cache model state
    logic        m_valid [SLOTS];
    logic [31:0] m_key [SLOTS];
    logic [7:0]  m_count [SLOTS];
    logic        m_cached [SLOTS];
    int          m_age [SLOTS];
    int          m_total;
    int          m_limit;

    beat_t       pending_beats[$];
    int          errors;
    int          idle_cycles;
    bit          rx_idle_ok;
    bit          rx_hold;
    bit          tx_idle_ok;
    logic [31:0] pool [8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("error: %s got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic int lookup(input logic [31:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (m_valid[i] && m_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < SLOTS; i++)
            if (!m_valid[i])
                return i;
        return -1;
    endfunction

    function automatic void add_beat(input logic kind, input logic [31:0] key,
                                     input logic [2:0] st, input logic [7:0] cnt,
                                     input logic last);
        beat_t b;
        b.kind = kind; b.okey = key; b.status = st; b.cnt = cnt; b.last = last;
        pending_beats = {pending_beats, b};
    endfunction

    function automatic void drop_from_list(input int s);
        for (int j = 0; j < SLOTS; j++)
            if (m_valid[j] && m_cached[j] && m_age[j] > m_age[s])
                m_age[j]--;
        m_cached[s] = 1'b0;
        m_age[s] = 0;
        if (m_total > 0)
            m_total--;
    endfunction

    function automatic void make_newest(input int s);
        for (int j = 0; j < SLOTS; j++)
            if (m_valid[j] && m_cached[j])
                m_age[j]++;
        m_cached[s] = 1'b1;
        m_age[s] = 0;
        m_count[s] = 0;
        m_total++;
    endfunction

    function automatic bit evict_lru();
        int b;
        b = -1;
        for (int i = 0; i < SLOTS; i++)
            if (m_valid[i] && m_cached[i] && (b < 0 || m_age[i] > m_age[b]))
                b = i;
        if (b < 0)
            return 0;
        add_beat(KIND_WB, m_key[b], ST_OK, 8'd0, 1'b0);
        drop_from_list(b);
        m_valid[b] = 1'b0;
        m_count[b] = 0;
        return 1;
    endfunction

    function automatic void trim_list();
        int lim;
        lim = (m_limit < 1) ? 1 : m_limit;
        while (m_total > lim)
            if (!evict_lru())
                break;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < SLOTS; i++)
        begin
            m_valid[i] = 0; m_key[i] = 0; m_count[i] = 0; m_cached[i] = 0; m_age[i] = 0;
        end
        m_total = 0;
        m_limit = 16;
    endfunction

    function automatic void predict_cache(input logic [2:0] mode, input logic [31:0] key,
                                          input logic pin);
        int k;
        logic [2:0] st;
        k = lookup(key);
        case (mode)
            MODE_PUT:
            begin
                st = ST_OK;
                if (k >= 0)
                begin
                    if (m_cached[k])
                        drop_from_list(k);
                    st = ST_DUP;
                end
                else
                begin
                    k = free_slot();
                    if (k < 0)
                    begin
                        if (!evict_lru())
                        begin
                            add_beat(KIND_ANS, key, ST_FULL, 8'd0, 1'b1);
                            return;
                        end
                        k = free_slot();
                    end
                end
                m_valid[k] = 1'b1;
                m_key[k] = key;
                if (pin)
                begin
                    m_cached[k] = 1'b0;
                    m_age[k] = 0;
                    m_count[k] = 1;
                end
                else
                begin
                    make_newest(k);
                    trim_list();
                end
                add_beat(KIND_ANS, key, st, m_count[k], 1'b1);
            end
            MODE_GET:
            begin
                if (k < 0)
                    add_beat(KIND_ANS, key, ST_MISS, 8'd0, 1'b1);
                else
                begin
                    if (m_cached[k])
                    begin
                        drop_from_list(k);
                        m_count[k] = 1;
                    end
                    else if (m_count[k] != 8'hFF)
                        m_count[k]++;
                    add_beat(KIND_ANS, key, ST_OK, m_count[k], 1'b1);
                end
            end
            MODE_REL:
            begin
                if (k < 0 || m_cached[k])
                    add_beat(KIND_ANS, key, ST_NUSE, 8'd0, 1'b1);
                else
                begin
                    if (m_count[k] > 0)
                        m_count[k]--;
                    if (m_count[k] == 0)
                    begin
                        make_newest(k);
                        trim_list();
                    end
                    add_beat(KIND_ANS, key, ST_OK, m_count[k], 1'b1);
                end
            end
            MODE_REMOVE:
            begin
                if (k < 0)
                    add_beat(KIND_ANS, key, ST_MISS, 8'd0, 1'b1);
                else
                begin
                    add_beat(KIND_WB, m_key[k], ST_OK, 8'd0, 1'b0);
                    if (m_cached[k])
                        drop_from_list(k);
                    m_valid[k] = 1'b0;
                    m_count[k] = 0;
                    add_beat(KIND_ANS, key, ST_OK, 8'd0, 1'b1);
                end
            end
            MODE_FLUSH:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (m_valid[i] && !m_cached[i])
                        add_beat(KIND_WB, m_key[i], ST_OK, 8'd0, 1'b0);
                for (int a = 0; a < m_total; a++)
                    for (int i = 0; i < SLOTS; i++)
                        if (m_valid[i] && m_cached[i] && m_age[i] == a)
                            add_beat(KIND_WB, m_key[i], ST_OK, 8'd0, 1'b0);
                for (int i = 0; i < SLOTS; i++)
                    if (m_valid[i] && m_cached[i])
                    begin
                        m_valid[i] = 0; m_cached[i] = 0; m_age[i] = 0; m_count[i] = 0;
                    end
                m_total = 0;
                add_beat(KIND_ANS, 32'd0, ST_OK, 8'd0, 1'b1);
            end
            default:
                add_beat(KIND_ANS, key, ST_MISS, 8'd0, 1'b1);
        endcase
    endfunction

    // output side: compare each beat with the oldest expectation
    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.kind = m_axis_tuser;
            got.okey = m_axis_tdata[31:0];
            got.status = m_axis_tdata[34:32];
            got.cnt = m_axis_tdata[42:35];
            got.last = m_axis_tlast;
            if (pending_beats.size() == 0)
                report("unexpected beat key", got.okey, 32'd0);
            else
            begin
                want = pending_beats.pop_front();
                if (got.kind != want.kind)
                    report("kind", got.kind, want.kind);
                if (got.okey != want.okey)
                    report("out_key", got.okey, want.okey);
                if (got.status != want.status)
                    report("status", got.status, want.status);
                if (got.cnt != want.cnt)
                    report("count", got.cnt, want.cnt);
                if (got.last != want.last)
                    report("last", got.last, want.last);
            end
        end
    end

    // receiver ready with random stall bursts
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold)
                m_axis_tready <= 1'b0;
            else if (rx_idle_ok && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 14);
                repeat (n - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT)
        begin
            $display("pinned_lru_object_cache_top: mismatch");
            $finish;
        end
    end

    task automatic send_item(input logic [2:0] mode, input logic [31:0] key, input logic pin);
        if (tx_idle_ok && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_axis_tdata <= {4'd0, pin, key, mode};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_cache(mode, key, pin);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_limit(input logic [5:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        m_limit = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return {$urandom};
            default: return pool[$urandom_range(0, 7)];
        endcase
    endfunction

    task automatic random_items(input int count, input int keys_hi);
        logic [2:0] mode;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 19))
                0: mode = MODE_FLUSH;
                1: mode = 3'($urandom_range(5, 7));
                2, 3: mode = MODE_REMOVE;
                4, 5, 6, 7, 8: mode = MODE_GET;
                9, 10, 11, 12: mode = MODE_REL;
                default: mode = MODE_PUT;
            endcase
            if ($urandom_range(0, 4) == 0)
                send_item(mode, pick_key(), 1'($urandom));
            else
                send_item(mode, 32'($urandom_range(1, keys_hi)), 1'($urandom));
        end
    endtask

    row_t dir_rows[$];

    function automatic row_t mk(input logic [2:0] mode, input logic [31:0] key,
                                input logic pin, input logic chk,
                                input logic [2:0] st, input logic [7:0] cnt);
        row_t r;
        r.mode = mode; r.key = key; r.pin = pin; r.chk = chk;
        r.exp_status = st; r.exp_count = cnt;
        return r;
    endfunction

    initial
    begin
        beat_t last_ans;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        rx_idle_ok = 1'b1;
        rx_hold = 1'b0;
        tx_idle_ok = 1'b1;
        for (int i = 0; i < 8; i++)
            pool[i] = {$urandom};
        pool[0] = 32'hFFFF_FFFF;
        pool[1] = 32'h0000_0000;
        reset_model();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        dir_rows = {dir_rows, mk(MODE_GET, 32'h0, 0, 1, ST_MISS, 8'd0)};
        dir_rows = {dir_rows, mk(MODE_REL, 32'hFFFF_FFFF, 0, 1, ST_NUSE, 8'd0)};
        dir_rows = {dir_rows, mk(MODE_REMOVE, 32'h5555_AAAA, 0, 1, ST_MISS, 8'd0)};
        dir_rows = {dir_rows, mk(3'd5, 32'h1234_5678, 1, 1, ST_MISS, 8'd0)};
        dir_rows = {dir_rows, mk(3'd7, 32'hFFFF_FFFF, 1, 1, ST_MISS, 8'd0)};
        dir_rows = {dir_rows, mk(MODE_PUT, 32'hFFFF_FFFF, 1, 1, ST_OK, 8'd1)};
        dir_rows = {dir_rows, mk(MODE_PUT, 32'h0, 0, 1, ST_OK, 8'd0)};
        dir_rows = {dir_rows, mk(MODE_PUT, 32'h0, 1, 1, ST_DUP, 8'd1)};
        dir_rows = {dir_rows, mk(MODE_PUT, 32'hAAAA_5555, 0, 0, 0, 0)};
        dir_rows = {dir_rows, mk(MODE_GET, 32'hAAAA_5555, 0, 0, 0, 0)};
        dir_rows = {dir_rows, mk(MODE_GET, 32'hFFFF_FFFF, 0, 0, 0, 0)};
        dir_rows = {dir_rows, mk(MODE_REL, 32'hFFFF_FFFF, 0, 0, 0, 0)};
        dir_rows = {dir_rows, mk(MODE_REL, 32'hFFFF_FFFF, 0, 0, 0, 0)};
        dir_rows = {dir_rows, mk(MODE_REL, 32'hFFFF_FFFF, 0, 1, ST_NUSE, 8'd0)};
        dir_rows = {dir_rows, mk(MODE_PUT, 32'h0000_0001, 1, 0, 0, 0)};
        dir_rows = {dir_rows, mk(MODE_FLUSH, 32'h0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, mk(MODE_REMOVE, 32'h0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, mk(MODE_PUT, 32'h0000_0002, 0, 0, 0, 0)};
        dir_rows = {dir_rows, mk(MODE_REMOVE, 32'h0000_0002, 0, 0, 0, 0)};

        foreach (dir_rows[r])
        begin
            send_item(dir_rows[r].mode, dir_rows[r].key, dir_rows[r].pin);
            if (dir_rows[r].chk)
            begin
                last_ans = pending_beats[pending_beats.size() - 1];
                if (last_ans.status != dir_rows[r].exp_status)
                    report("table status", last_ans.status, dir_rows[r].exp_status);
                if (last_ans.cnt != dir_rows[r].exp_count)
                    report("table count", last_ans.cnt, dir_rows[r].exp_count);
            end
        end
        drain();

        // full table: fill with pinned keys, then every put reports full; then flush and remove each pinned key
        write_limit(6'd1);
        send_item(MODE_PUT, 32'hC000_0000, 0);
        for (int i = 0; i < SLOTS; i++)
            send_item(MODE_PUT, 32'hB000_0000 + i, 1);
        send_item(MODE_PUT, 32'hD000_0000, 0);
        send_item(MODE_PUT, 32'hD000_0001, 1);
        send_item(MODE_FLUSH, 32'h0, 0);
        for (int i = 0; i < SLOTS; i++)
            send_item(MODE_REMOVE, 32'hB000_0000 + i, 0);
        drain();

        // long receiver hold while the sender keeps offering
        write_limit(6'd32);
        rx_hold = 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                rx_hold = 1'b0;
            end
            random_items(30, 40);
        join
        drain();

        write_limit(6'd0);
        random_items(40, 12);
        drain();
        write_limit(6'd63);
        random_items(40, 48);
        drain();
        write_limit(6'd4);
        random_items(30, 16);
        rx_idle_ok = 1'b0;
        tx_idle_ok = 1'b0;
        random_items(25, 16);
        send_item(MODE_FLUSH, 32'h0, 0);
        drain();

        if (errors == 0)
            $display("pinned_lru_object_cache_top: match");
        else
            $display("pinned_lru_object_cache_top: mismatch");
        $finish;
    end
endmodule
